// File: rtl/lsc_pkg.sv
// Shared types, constants and helpers for the lap stopwatch controller.
// No dependencies; every other file in rtl/ imports this package.
package lsc_pkg;

    localparam int NUM_KEYS  = 3;
    localparam int KEY_START = 0;
    localparam int KEY_CLEAR = 1;
    localparam int KEY_LAP   = 2;

    localparam logic [6:0] MINUTE_LIMIT     = 7'd99;
    localparam logic [5:0] SECOND_LAST      = 6'd59;
    localparam logic [6:0] CENTISECOND_LAST = 7'd99;

    localparam logic [2:0] CHASER_LAST = 3'd5;
    localparam logic [5:0] CHASER_ONE  = 6'h01;
    localparam logic [5:0] CHASER_DARK = 6'h3F;

    // Active-low blinker patterns.
    localparam logic [1:0] BLINK_ODD  = 2'b01;
    localparam logic [1:0] BLINK_EVEN = 2'b10;
    localparam logic [1:0] BLINK_OFF  = 2'b11;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;
    localparam logic [1:0] MODE_FROZEN  = 2'd3;

    localparam logic [1:0] CFG_TICKS_PER_CS = 2'd0;
    localparam logic [1:0] CFG_FREEZE_TICKS = 2'd1;
    localparam logic [1:0] CFG_CHASER_TICKS = 2'd2;
    localparam logic [1:0] CFG_DEBOUNCE     = 2'd3;

    localparam logic [15:0] RST_TICKS_PER_CS = 16'd10;
    localparam logic [15:0] RST_FREEZE_TICKS = 16'd3000;
    localparam logic [15:0] RST_CHASER_TICKS = 16'd500;
    localparam logic [7:0]  RST_DEBOUNCE     = 8'd20;

    typedef enum logic [3:0] {
        ST_STOPPED = 4'b0001,
        ST_RUNNING = 4'b0010,
        ST_PAUSED  = 4'b0100,
        ST_FROZEN  = 4'b1000
    } mode_state_t;

    typedef struct packed {
        logic [6:0] minute;
        logic [5:0] second;
        logic [6:0] centisecond;
    } time_t;

    typedef struct packed {
        mode_state_t mode;
        logic        sec_odd;
    } lsc_status_t;

    typedef struct packed {
        logic key_start_pause;
        logic key_clear;
        logic key_lap;
    } in_word_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] shown_minute;
        logic [5:0] shown_second;
        logic [6:0] shown_centisecond;
        logic [7:0] led_pattern;
    } out_word_t;

    function automatic logic [1:0] mode_code(input mode_state_t st);
        logic [1:0] code;
        unique case (st)
            ST_STOPPED: code = MODE_STOPPED;
            ST_RUNNING: code = MODE_RUNNING;
            ST_PAUSED:  code = MODE_PAUSED;
            ST_FROZEN:  code = MODE_FROZEN;
            default:    code = MODE_STOPPED;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/lsc_debounce.sv
// One key lane: stable-level debounce counter and press detection.
// Depends on lsc_pkg.
module lsc_debounce (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       raw,
    input  logic [7:0] debounce_ticks,
    output logic       fire
);
    import lsc_pkg::*;

    logic       last_reg, last_next;
    logic       stable_reg, stable_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] hold_inc;

    assign hold_inc = hold_reg + 8'd1;

    always_comb
    begin
        fire        = 1'b0;
        last_next   = last_reg;
        stable_next = stable_reg;
        hold_next   = hold_reg;
        if (raw == last_reg)
        begin
            if (hold_reg < debounce_ticks)
            begin
                hold_next = hold_inc;
                if (hold_inc >= debounce_ticks)
                begin
                    fire        = !stable_reg && raw;
                    stable_next = raw;
                end
            end
        end
        else
        begin
            last_next = raw;
            hold_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 1'b0;
            stable_reg <= 1'b0;
            hold_reg   <= 8'd0;
        end
        else if (step)
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

// File: rtl/lsc_timekeeper.sv
// Mode machine, running time, lap capture, centisecond divider and freeze timer.
// Depends on lsc_pkg.
module lsc_timekeeper (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [2:0]               press,
    input  logic [15:0]              ticks_per_cs,
    input  logic [15:0]              freeze_ticks,
    output lsc_pkg::lsc_status_t     status,
    output lsc_pkg::time_t           shown
);
    import lsc_pkg::*;

    mode_state_t mode_reg, mode_next;
    time_t       run_reg, run_next;
    time_t       lap_reg, lap_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] freeze_reg, freeze_next;
    logic [15:0] div_inc, freeze_inc;

    assign div_inc = div_reg + 16'd1;

    // Key actions apply in order start/pause, clear, lap; each sees the
    // mode left by the one before it.
    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        lap_next    = lap_reg;
        freeze_next = freeze_reg;
        div_next    = div_inc;
        freeze_inc  = 16'd0;

        if (press[KEY_START])
        begin
            unique case (mode_next)
                ST_RUNNING: mode_next = ST_PAUSED;
                ST_FROZEN:
                begin
                    freeze_next = 16'd0;
                    mode_next   = ST_PAUSED;
                end
                ST_STOPPED:
                begin
                    run_next  = '0;
                    mode_next = ST_RUNNING;
                end
                ST_PAUSED:  mode_next = ST_RUNNING;
                default:    mode_next = ST_STOPPED;
            endcase
        end

        if (press[KEY_CLEAR] && (mode_next == ST_PAUSED || mode_next == ST_STOPPED))
        begin
            run_next    = '0;
            freeze_next = 16'd0;
            mode_next   = ST_STOPPED;
        end

        if (press[KEY_LAP] && mode_next == ST_RUNNING)
        begin
            lap_next    = run_next;
            freeze_next = 16'd0;
            mode_next   = ST_FROZEN;
        end

        if (div_inc >= ticks_per_cs)
        begin
            div_next = 16'd0;
            if (mode_next == ST_RUNNING || mode_next == ST_FROZEN)
            begin
                if (run_next.centisecond < CENTISECOND_LAST)
                begin
                    run_next.centisecond = run_next.centisecond + 7'd1;
                end
                else
                begin
                    run_next.centisecond = 7'd0;
                    if (run_next.second < SECOND_LAST)
                    begin
                        run_next.second = run_next.second + 6'd1;
                    end
                    else
                    begin
                        run_next.second = 6'd0;
                        if (run_next.minute < MINUTE_LIMIT)
                        begin
                            run_next.minute = run_next.minute + 7'd1;
                        end
                        else
                        begin
                            // Wrapped past the top of the display: stop at zero.
                            run_next  = '0;
                            mode_next = ST_STOPPED;
                        end
                    end
                end
            end
        end

        if (mode_next == ST_FROZEN)
        begin
            freeze_inc = freeze_next + 16'd1;
            if (freeze_inc >= freeze_ticks)
            begin
                freeze_next = 16'd0;
                mode_next   = ST_RUNNING;
            end
            else
            begin
                freeze_next = freeze_inc;
            end
        end
    end

    assign status.mode    = mode_next;
    assign status.sec_odd = run_next.second[0];
    assign shown          = (mode_next == ST_FROZEN) ? lap_next : run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ST_STOPPED;
            run_reg    <= '0;
            lap_reg    <= '0;
            div_reg    <= 16'd0;
            freeze_reg <= 16'd0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            lap_reg    <= lap_next;
            div_reg    <= div_next;
            freeze_reg <= freeze_next;
        end
    end

endmodule

// File: rtl/lsc_led.sv
// LED pattern: seconds blinker and six-LED chaser, all active low.
// Depends on lsc_pkg.
module lsc_led (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lsc_pkg::lsc_status_t status,
    input  logic [15:0]          chaser_ticks,
    output logic [7:0]           led_pattern
);
    import lsc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [2:0]  pos_reg, pos_next;
    logic [5:0]  lit_reg, lit_next;
    logic [15:0] count_inc;
    logic [2:0]  pos_inc;
    logic [1:0]  blink;

    assign count_inc = count_reg + 16'd1;
    assign pos_inc   = pos_reg + 3'd1;

    always_comb
    begin
        count_next = count_inc;
        pos_next   = pos_reg;
        lit_next   = lit_reg;
        if (count_inc >= chaser_ticks)
        begin
            count_next = 16'd0;
            pos_next   = (pos_inc > CHASER_LAST) ? 3'd0 : pos_inc;
            lit_next   = CHASER_DARK & ~(CHASER_ONE << pos_next);
        end
    end

    always_comb
    begin
        if (status.mode == ST_RUNNING || status.mode == ST_FROZEN)
        begin
            blink = status.sec_odd ? BLINK_ODD : BLINK_EVEN;
        end
        else
        begin
            blink = BLINK_OFF;
        end
    end

    assign led_pattern = {lit_next, blink};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            pos_reg   <= 3'd0;
            lit_reg   <= CHASER_DARK;
        end
        else if (step)
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            lit_reg   <= lit_next;
        end
    end

endmodule

// File: rtl/lap_stopwatch_controller_top.sv
// Top level of the lap stopwatch controller: config registers, input and
// result registers. Depends on lsc_pkg, lsc_debounce, lsc_timekeeper, lsc_led.
//
// Usage: each input word is one timebase tick carrying the raw levels of the
// start/pause, clear and lap keys. Every accepted word produces exactly one
// result word with the mode, the shown time (the lap time while frozen) and
// the active-low LED pattern.
// Both channels use valid/stall; a word moves on a clock edge where valid is
// high and stall is low. An accepted word waits in the input register, is
// processed in a single pass and lands in the result register when it
// advances, which raises out_valid. One word per cycle is sustained while the
// receiver does not stall, as the counters update in that same pass.
// When the receiver stalls, the result register holds its word and the input
// register fills; in_stall rises only when both are occupied.
// Reset (rst_n, asynchronous, active low) stops the watch at 00:00.00, turns
// all LEDs off, clears the key filters and loads the register defaults.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user
// writes it only while no word is in flight; the block does not enforce it.
module lap_stopwatch_controller_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lsc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output lsc_pkg::out_word_t out_word,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    import lsc_pkg::*;

    logic [15:0] ticks_per_cs_reg;
    logic [15:0] freeze_ticks_reg;
    logic [15:0] chaser_ticks_reg;
    logic [7:0]  debounce_reg;

    logic        s1_valid_reg;
    in_word_t    s1_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic        advance;

    logic [2:0]  raw_keys;
    logic [2:0]  press;
    lsc_status_t status;
    time_t       shown;
    logic [7:0]  led_pattern;
    out_word_t   result;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_cs_reg <= RST_TICKS_PER_CS;
            freeze_ticks_reg <= RST_FREEZE_TICKS;
            chaser_ticks_reg <= RST_CHASER_TICKS;
            debounce_reg     <= RST_DEBOUNCE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_TICKS_PER_CS: ticks_per_cs_reg <= cfg_wdata;
                CFG_FREEZE_TICKS: freeze_ticks_reg <= cfg_wdata;
                CFG_CHASER_TICKS: chaser_ticks_reg <= cfg_wdata;
                CFG_DEBOUNCE:     debounce_reg     <= cfg_wdata[7:0];
                default:          debounce_reg     <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_word_reg <= in_word;
        end
    end

    assign raw_keys[KEY_START] = s1_word_reg.key_start_pause;
    assign raw_keys[KEY_CLEAR] = s1_word_reg.key_clear;
    assign raw_keys[KEY_LAP]   = s1_word_reg.key_lap;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        lsc_debounce u_debounce (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (advance),
            .raw            (raw_keys[k]),
            .debounce_ticks (debounce_reg),
            .fire           (press[k])
        );
    end

    lsc_timekeeper u_timekeeper (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .press        (press),
        .ticks_per_cs (ticks_per_cs_reg),
        .freeze_ticks (freeze_ticks_reg),
        .status       (status),
        .shown        (shown)
    );

    lsc_led u_led (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .status       (status),
        .chaser_ticks (chaser_ticks_reg),
        .led_pattern  (led_pattern)
    );

    always_comb
    begin
        result.mode              = mode_code(status.mode);
        result.shown_minute      = shown.minute;
        result.shown_second      = shown.second;
        result.shown_centisecond = shown.centisecond;
        result.led_pattern       = led_pattern;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
